// ===== src/mcur_pkg.sv =====
// ============================================================================
// mcur_pkg - shared types and constants for the mouse cursor tracker
// Packet record, state encodings and default screen geometry.
// ============================================================================
package mcur_pkg;

    // default geometry, handed down as top-level parameter defaults
    localparam int COLS_DEFAULT = 80;
    localparam int ROWS_DEFAULT = 25;
    localparam int TERM_DEFAULT = 3;

    localparam int PICK_COL_LIMIT = 32;
    localparam int SWITCH_ROW     = 1;
    localparam int MENU_ROW       = 2;

    localparam logic [3:0] SENS_RESET = 4'd2;

    // packet queue between front and back
    localparam int QUEUE_DEPTH = 2;

    // restoring divide, one quotient bit per cycle over a 9-bit magnitude
    localparam int MAG_W     = 9;
    localparam int DIV_STEPS = MAG_W;

    // status byte bit positions
    localparam int ST_LEFT   = 0;
    localparam int ST_SYNC   = 3;
    localparam int ST_X_SIGN = 4;
    localparam int ST_Y_SIGN = 5;
    localparam int ST_X_OVF  = 6;
    localparam int ST_Y_OVF  = 7;

    typedef enum logic [1:0] {
        PH_STATUS,
        PH_XMOVE,
        PH_YMOVE
    } t_phase;

    typedef enum logic [1:0] {
        BK_IDLE,
        BK_DIV,
        BK_WRITE
    } t_back_state;

    // checked packet, only the status bits the back end needs
    typedef struct packed {
        logic       left;
        logic       x_neg;
        logic       y_neg;
        logic [7:0] x_low;
        logic [7:0] y_low;
    } t_mpkt;

    // handshake between queue and its two users
    typedef struct packed {
        logic full;
        logic empty;
    } t_qstat;

endpackage

// ===== src/ps2_mouse_cursor_tracker.sv =====
// ============================================================================
// ps2_mouse_cursor_tracker - PS/2 three-byte packet decoder, text cursor
// Usage:
//   Input channel (i_in_valid / o_in_stall / i_data_byte) takes one raw
//   mouse byte per request, in packet order; every third byte ends a packet.
//   Bytes are taken one per cycle; only the third byte of a packet can stall,
//   and only while the two-entry packet queue is full.
//   Output channel (o_out_valid / i_out_stall) gives one result per good
//   packet. Bad packets (sync bit clear or an overflow bit set) give none.
//   Config channel (i_cfg_valid / o_cfg_ready / i_sensitivity) writes the
//   movement divisor; always ready, write it only while the block is idle.
// Operation:
//   The mover fetches a packet from the queue, runs 9 steps of the
//   bit-serial divider, then updates the cursor and loads the result
//   register; it takes no new packet until it is through with the last.
//   A stalled result holds its register; the mover then waits in its final
//   step while the queue keeps taking bytes.
// Reset:
//   Synchronous active-low; cursor home, terminal 0, sensitivity 2, queue
//   emptied. No clearing pass, the block is ready on the next cycle.
// ============================================================================
module ps2_mouse_cursor_tracker import mcur_pkg::*; #(
    parameter int SCREEN_COLS = COLS_DEFAULT,
    parameter int SCREEN_ROWS = ROWS_DEFAULT,
    parameter int TERM_COUNT  = TERM_DEFAULT
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_cfg_valid,
    output logic       o_cfg_ready,
    input  logic [3:0] i_sensitivity,
    input  logic       i_in_valid,
    output logic       o_in_stall,
    input  logic [7:0] i_data_byte,
    output logic       o_out_valid,
    input  logic       i_out_stall,
    output logic [6:0] o_cursor_col,
    output logic [4:0] o_cursor_row,
    output logic       o_left_pressed,
    output logic [1:0] o_terminal_index,
    output logic       o_switch_hit,
    output logic       o_menu_hit,
    output logic       o_pick_hit
);

    logic [3:0] r_sens;
    logic       w_push;
    logic       w_pop;
    t_mpkt      w_front_pkt;
    t_mpkt      w_queue_pkt;
    t_qstat     w_qstat;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sens <= SENS_RESET;
        end else if (i_cfg_valid && o_cfg_ready) begin
            r_sens <= i_sensitivity;
        end
    end

    mcur_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_data_byte (i_data_byte),
        .i_qstat     (w_qstat),
        .o_push      (w_push),
        .o_pkt       (w_front_pkt)
    );

    mcur_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_pkt   (w_front_pkt),
        .i_pop   (w_pop),
        .o_pkt   (w_queue_pkt),
        .o_qstat (w_qstat)
    );

    mcur_back #(
        .SCREEN_COLS (SCREEN_COLS),
        .SCREEN_ROWS (SCREEN_ROWS),
        .TERM_COUNT  (TERM_COUNT)
    ) u_back (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_sensitivity    (r_sens),
        .i_pkt            (w_queue_pkt),
        .i_qstat          (w_qstat),
        .o_pop            (w_pop),
        .o_out_valid      (o_out_valid),
        .i_out_stall      (i_out_stall),
        .o_cursor_col     (o_cursor_col),
        .o_cursor_row     (o_cursor_row),
        .o_left_pressed   (o_left_pressed),
        .o_terminal_index (o_terminal_index),
        .o_switch_hit     (o_switch_hit),
        .o_menu_hit       (o_menu_hit),
        .o_pick_hit       (o_pick_hit)
    );

endmodule

// ===== src/mcur_front.sv =====
// ============================================================================
// mcur_front - byte gatherer
// Collects three mouse bytes per packet, checks the status byte and pushes
// good packets into the queue. Bad packets are dropped silently.
// ============================================================================
module mcur_front import mcur_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_in_valid,
    output logic       o_in_stall,
    input  logic [7:0] i_data_byte,
    input  t_qstat     i_qstat,
    output logic       o_push,
    output t_mpkt      o_pkt
);

    t_phase     r_phase, n_phase;
    logic [7:0] r_status;
    logic [7:0] r_xbyte;
    logic       w_accept;
    logic       w_good;

    // hold the last byte back only while there is no room for the packet
    assign o_in_stall = (r_phase == PH_YMOVE) && i_qstat.full;
    assign w_accept   = i_in_valid && !o_in_stall;

    assign w_good = r_status[ST_SYNC] && !r_status[ST_X_OVF] && !r_status[ST_Y_OVF];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_STATUS;
        end else begin
            r_phase <= n_phase;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept && r_phase == PH_STATUS) begin
            r_status <= i_data_byte;
        end
        if (w_accept && r_phase == PH_XMOVE) begin
            r_xbyte <= i_data_byte;
        end
    end

    always_comb begin
        n_phase = r_phase;
        o_push  = 1'b0;
        case (r_phase)
            PH_STATUS: begin
                if (w_accept) n_phase = PH_XMOVE;
            end
            PH_XMOVE: begin
                if (w_accept) n_phase = PH_YMOVE;
            end
            PH_YMOVE: begin
                if (w_accept) begin
                    n_phase = PH_STATUS;
                    o_push  = w_good;
                end
            end
            default: n_phase = PH_STATUS;
        endcase
    end

    assign o_pkt.left  = r_status[ST_LEFT];
    assign o_pkt.x_neg = r_status[ST_X_SIGN];
    assign o_pkt.y_neg = r_status[ST_Y_SIGN];
    assign o_pkt.x_low = r_xbyte;
    assign o_pkt.y_low = i_data_byte;

endmodule

// ===== src/mcur_queue.sv =====
// ============================================================================
// mcur_queue - short packet queue
// Small circular buffer decoupling the byte gatherer from the mover.
// ============================================================================
module mcur_queue import mcur_pkg::*; #(
    parameter int DEPTH = QUEUE_DEPTH
) (
    input  logic   i_clk,
    input  logic   i_rst_n,
    input  logic   i_push,
    input  t_mpkt  i_pkt,
    input  logic   i_pop,
    output t_mpkt  o_pkt,
    output t_qstat o_qstat
);

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);
    localparam logic [AW-1:0] LAST_PTR = AW'(DEPTH - 1);
    localparam logic [CW-1:0] FULL_CNT = CW'(DEPTH);

    t_mpkt         r_mem [DEPTH];
    logic [AW-1:0] r_wr, n_wr;
    logic [AW-1:0] r_rd, n_rd;
    logic [CW-1:0] r_count, n_count;
    logic          w_push;
    logic          w_pop;

    assign o_qstat.full  = (r_count == FULL_CNT);
    assign o_qstat.empty = (r_count == '0);
    assign w_push = i_push && !o_qstat.full;
    assign w_pop  = i_pop && !o_qstat.empty;
    assign o_pkt  = r_mem[r_rd];

    always_comb begin
        n_wr    = r_wr;
        n_rd    = r_rd;
        n_count = r_count;
        if (w_push) n_wr = (r_wr == LAST_PTR) ? '0 : r_wr + 1'b1;
        if (w_pop)  n_rd = (r_rd == LAST_PTR) ? '0 : r_rd + 1'b1;
        if (w_push && !w_pop) n_count = r_count + 1'b1;
        if (w_pop && !w_push) n_count = r_count - 1'b1;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            r_wr    <= n_wr;
            r_rd    <= n_rd;
            r_count <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_mem[r_wr] <= i_pkt;
        end
    end

endmodule

// ===== src/mcur_back.sv =====
// ============================================================================
// mcur_back - cursor mover
// Divides both movements by the sensitivity bit-serially, moves and clamps
// the cursor, works out hotspot hits and holds the result for the receiver.
// ============================================================================
module mcur_back import mcur_pkg::*; #(
    parameter int SCREEN_COLS = COLS_DEFAULT,
    parameter int SCREEN_ROWS = ROWS_DEFAULT,
    parameter int TERM_COUNT  = TERM_DEFAULT
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic [3:0] i_sensitivity,
    input  t_mpkt      i_pkt,
    input  t_qstat     i_qstat,
    output logic       o_pop,
    output logic       o_out_valid,
    input  logic       i_out_stall,
    output logic [6:0] o_cursor_col,
    output logic [4:0] o_cursor_row,
    output logic       o_left_pressed,
    output logic [1:0] o_terminal_index,
    output logic       o_switch_hit,
    output logic       o_menu_hit,
    output logic       o_pick_hit
);

    localparam logic signed [10:0] COL_LAST_S = 11'(SCREEN_COLS - 1);
    localparam logic signed [10:0] ROW_LAST_S = 11'(SCREEN_ROWS - 1);
    localparam logic [6:0]  COL_LAST  = 7'(SCREEN_COLS - 1);
    localparam logic [6:0]  PICK_COL  = 7'(PICK_COL_LIMIT);
    localparam logic [4:0]  SW_ROW    = 5'(SWITCH_ROW);
    localparam logic [4:0]  MN_ROW    = 5'(MENU_ROW);
    localparam logic [1:0]  TERM_LAST = 2'(TERM_COUNT - 1);
    localparam logic [3:0]  STEP_LAST = 4'(DIV_STEPS - 1);

    t_back_state      r_state, n_state;
    logic [3:0]       r_step;
    logic [3:0]       r_div;
    logic             r_left, r_x_neg, r_y_neg;
    logic [MAG_W-1:0] r_qx, r_qy;
    logic [3:0]       r_rem_x, r_rem_y;

    logic [6:0]       r_col;
    logic [4:0]       r_row;
    logic [1:0]       r_term;
    logic             r_out_valid;

    logic [4:0]        w_sh_x, w_sh_y;
    logic              w_ge_x, w_ge_y;
    logic [MAG_W-1:0]  w_mag_x, w_mag_y;
    logic signed [10:0] w_dx, w_dy, w_col_raw, w_row_raw;
    logic [6:0]        w_col;
    logic [4:0]        w_row;
    logic              w_sw, w_menu, w_pick;
    logic              w_load;

    // 9-bit magnitudes; a negative byte stands for byte - 256
    assign w_mag_x = i_pkt.x_neg ? MAG_W'(10'd256 - {2'b00, i_pkt.x_low})
                                 : {1'b0, i_pkt.x_low};
    assign w_mag_y = i_pkt.y_neg ? MAG_W'(10'd256 - {2'b00, i_pkt.y_low})
                                 : {1'b0, i_pkt.y_low};

    // one restoring step on each lane
    assign w_sh_x = {r_rem_x, r_qx[MAG_W-1]};
    assign w_sh_y = {r_rem_y, r_qy[MAG_W-1]};
    assign w_ge_x = (w_sh_x >= {1'b0, r_div});
    assign w_ge_y = (w_sh_y >= {1'b0, r_div});

    // quotient of magnitudes, sign put back: truncates toward zero
    assign w_dx = r_x_neg ? -$signed({2'b00, r_qx}) : $signed({2'b00, r_qx});
    assign w_dy = r_y_neg ? -$signed({2'b00, r_qy}) : $signed({2'b00, r_qy});
    assign w_col_raw = $signed({4'b0000, r_col}) + w_dx;
    assign w_row_raw = $signed({6'b000000, r_row}) - w_dy;

    always_comb begin
        if (w_col_raw < 0)               w_col = '0;
        else if (w_col_raw > COL_LAST_S) w_col = COL_LAST;
        else                             w_col = w_col_raw[6:0];
        if (w_row_raw < 0)               w_row = '0;
        else if (w_row_raw > ROW_LAST_S) w_row = ROW_LAST_S[4:0];
        else                             w_row = w_row_raw[4:0];
    end

    assign w_sw   = r_left && (w_col == COL_LAST) && (w_row == SW_ROW);
    assign w_menu = r_left && (w_col == COL_LAST) && (w_row == MN_ROW);
    assign w_pick = r_left && (w_col < PICK_COL);

    always_comb begin
        n_state = r_state;
        o_pop   = 1'b0;
        w_load  = 1'b0;
        case (r_state)
            BK_IDLE: begin
                if (!i_qstat.empty) begin
                    o_pop   = 1'b1;
                    n_state = BK_DIV;
                end
            end
            BK_DIV: begin
                if (r_step == STEP_LAST) n_state = BK_WRITE;
            end
            BK_WRITE: begin
                // wait for the output register to free up
                if (!r_out_valid || !i_out_stall) begin
                    w_load  = 1'b1;
                    n_state = BK_IDLE;
                end
            end
            default: n_state = BK_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= BK_IDLE;
            r_col       <= '0;
            r_row       <= '0;
            r_term      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (w_load) begin
                r_col       <= w_col;
                r_row       <= w_row;
                r_out_valid <= 1'b1;
                if (w_sw) r_term <= (r_term >= TERM_LAST) ? '0 : r_term + 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_step  <= '0;
            r_div   <= (i_sensitivity == '0) ? 4'd1 : i_sensitivity;
            r_left  <= i_pkt.left;
            r_x_neg <= i_pkt.x_neg;
            r_y_neg <= i_pkt.y_neg;
            r_qx    <= w_mag_x;
            r_qy    <= w_mag_y;
            r_rem_x <= '0;
            r_rem_y <= '0;
        end else if (r_state == BK_DIV) begin
            r_step  <= r_step + 1'b1;
            r_qx    <= {r_qx[MAG_W-2:0], w_ge_x};
            r_qy    <= {r_qy[MAG_W-2:0], w_ge_y};
            r_rem_x <= w_ge_x ? 4'(w_sh_x - {1'b0, r_div}) : w_sh_x[3:0];
            r_rem_y <= w_ge_y ? 4'(w_sh_y - {1'b0, r_div}) : w_sh_y[3:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_load) begin
            o_cursor_col     <= w_col;
            o_cursor_row     <= w_row;
            o_left_pressed   <= r_left;
            o_terminal_index <= (w_sw) ? ((r_term >= TERM_LAST) ? '0 : r_term + 1'b1)
                                       : r_term;
            o_switch_hit     <= w_sw;
            o_menu_hit       <= w_menu;
            o_pick_hit       <= w_pick;
        end
    end

    assign o_out_valid = r_out_valid;

endmodule

// ===== src/mcur_checker.sv =====
// ============================================================================
// mcur_checker - port-level checks for the cursor tracker
// Watches the result channel for held requests and sane cursor reports.
// ============================================================================
module mcur_checker import mcur_pkg::*; #(
    parameter int SCREEN_COLS = COLS_DEFAULT,
    parameter int SCREEN_ROWS = ROWS_DEFAULT,
    parameter int TERM_COUNT  = TERM_DEFAULT
) (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       o_out_valid,
    input logic       i_out_stall,
    input logic [6:0] o_cursor_col,
    input logic [4:0] o_cursor_row,
    input logic       o_left_pressed,
    input logic [1:0] o_terminal_index,
    input logic       o_switch_hit,
    input logic       o_pick_hit
);

    localparam logic [6:0] COL_LAST  = 7'(SCREEN_COLS - 1);
    localparam logic [4:0] ROW_LAST  = 5'(SCREEN_ROWS - 1);
    localparam logic [2:0] TERM_N    = 3'(TERM_COUNT);
    localparam logic [6:0] PICK_COL  = 7'(PICK_COL_LIMIT);
    localparam logic [4:0] SW_ROW    = 5'(SWITCH_ROW);

    a_hold_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid)
        else $error("result request dropped while stalled");

    a_hold_data: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> $stable(o_cursor_col) && $stable(o_cursor_row)
                                       && $stable(o_terminal_index))
        else $error("stalled result changed");

    a_on_screen: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_cursor_col <= COL_LAST) && (o_cursor_row <= ROW_LAST)
                        && ({1'b0, o_terminal_index} < TERM_N))
        else $error("cursor or terminal out of range");

    a_switch_spot: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_switch_hit |-> o_left_pressed && (o_cursor_col == COL_LAST)
                                        && (o_cursor_row == SW_ROW))
        else $error("terminal switch outside its hotspot");

    a_pick_spot: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_pick_hit |-> o_left_pressed && (o_cursor_col < PICK_COL))
        else $error("pick reported outside pick area");

endmodule

bind ps2_mouse_cursor_tracker mcur_checker #(
    .SCREEN_COLS (SCREEN_COLS),
    .SCREEN_ROWS (SCREEN_ROWS),
    .TERM_COUNT  (TERM_COUNT)
) u_mcur_checker (
    .i_clk            (i_clk),
    .i_rst_n          (i_rst_n),
    .o_out_valid      (o_out_valid),
    .i_out_stall      (i_out_stall),
    .o_cursor_col     (o_cursor_col),
    .o_cursor_row     (o_cursor_row),
    .o_left_pressed   (o_left_pressed),
    .o_terminal_index (o_terminal_index),
    .o_switch_hit     (o_switch_hit),
    .o_pick_hit       (o_pick_hit)
);

// ===== verif/ps2_mouse_cursor_tracker_tb.sv =====
// ============================================================================
// ps2_mouse_cursor_tracker_tb - self-checking bench for the mouse cursor tracker
// Feeds raw mouse bytes through the stall handshake, tracks packet phase, cursor
// and terminal in a local predictor and checks every cursor report against it
// or a hand-typed value. A short table of hand-picked packets comes first, then
// mostly well-formed random packets with stray bytes, bad packets and changes
// of sensitivity, random gaps on the byte side and stalls on the report side.
// ============================================================================
module ps2_mouse_cursor_tracker_tb;
    import mcur_pkg::*;

    localparam int COLS          = COLS_DEFAULT;
    localparam int ROWS          = ROWS_DEFAULT;
    localparam int TERMS         = TERM_DEFAULT;
    localparam int RANDOM_BYTES  = 1300;
    localparam int CALM_BYTES    = 150;
    localparam int DRAIN_CYCLES  = 48;
    localparam int QUIET_LIMIT   = 2000;
    localparam int REPORT_LIMIT  = 10;

    typedef struct packed {
        logic [6:0] col;
        logic [4:0] row;
        logic       left;
        logic [1:0] term;
        logic       sw;
        logic       menu;
        logic       pick;
    } cursor_rpt_t;

    typedef struct packed {
        logic [7:0]  st;
        logic [7:0]  xb;
        logic [7:0]  yb;
        logic        new_sens;
        logic [3:0]  sens;
        logic        pinned;
        logic        has_rpt;
        cursor_rpt_t want;
    } pkt_row_t;

    logic       i_clk         = 1'b0;
    logic       i_rst_n       = 1'b0;
    logic       i_cfg_valid   = 1'b0;
    logic [3:0] i_sensitivity = 4'd0;
    logic       i_in_valid    = 1'b0;
    logic [7:0] i_data_byte   = 8'd0;
    logic       i_out_stall   = 1'b0;
    logic       o_cfg_ready;
    logic       o_in_stall;
    logic       o_out_valid;
    logic [6:0] o_cursor_col;
    logic [4:0] o_cursor_row;
    logic       o_left_pressed;
    logic [1:0] o_terminal_index;
    logic       o_switch_hit;
    logic       o_menu_hit;
    logic       o_pick_hit;

    ps2_mouse_cursor_tracker i_dut (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cfg_valid      (i_cfg_valid),
        .o_cfg_ready      (o_cfg_ready),
        .i_sensitivity    (i_sensitivity),
        .i_in_valid       (i_in_valid),
        .o_in_stall       (o_in_stall),
        .i_data_byte      (i_data_byte),
        .o_out_valid      (o_out_valid),
        .i_out_stall      (i_out_stall),
        .o_cursor_col     (o_cursor_col),
        .o_cursor_row     (o_cursor_row),
        .o_left_pressed   (o_left_pressed),
        .o_terminal_index (o_terminal_index),
        .o_switch_hit     (o_switch_hit),
        .o_menu_hit       (o_menu_hit),
        .o_pick_hit       (o_pick_hit)
    );

    // predictor state, reset values
    t_phase     pr_phase  = PH_STATUS;
    logic [7:0] pr_status = 8'd0;
    logic [7:0] pr_xmove  = 8'd0;
    logic [6:0] pr_col    = 7'd0;
    logic [4:0] pr_row    = 5'd0;
    logic [1:0] pr_term   = 2'd0;
    logic [3:0] pr_sens   = SENS_RESET;

    cursor_rpt_t cursor_q[$];
    pkt_row_t    plan[$];

    // hand-typed expectation for the packet now being closed
    bit          pin_on  = 1'b0;
    bit          pin_has = 1'b0;
    cursor_rpt_t pin_val = '0;

    bit calm        = 1'b0;
    int drv_count   = 0;
    int n_bytes     = 0;
    int n_rpts      = 0;
    int n_cfg       = 0;
    int n_err       = 0;
    int quiet_cycles = 0;

    initial begin
        forever #10 i_clk = ~i_clk;
    end

    function automatic bit advance_cursor(input logic [7:0] b, output cursor_rpt_t rpt);
        int dx, dy, div, c, r;
        rpt = '0;
        case (pr_phase)
            PH_STATUS: begin
                pr_status = b;
                pr_phase  = PH_XMOVE;
                return 1'b0;
            end
            PH_XMOVE: begin
                pr_xmove = b;
                pr_phase = PH_YMOVE;
                return 1'b0;
            end
            default: begin
                pr_phase = PH_STATUS;
            end
        endcase
        if (!pr_status[ST_SYNC] || pr_status[ST_X_OVF] || pr_status[ST_Y_OVF])
            return 1'b0;
        dx  = pr_status[ST_X_SIGN] ? int'(pr_xmove) - 256 : int'(pr_xmove);
        dy  = pr_status[ST_Y_SIGN] ? int'(b) - 256 : int'(b);
        div = (pr_sens == 4'd0) ? 1 : int'(pr_sens);
        // int divide truncates toward zero, as wanted
        c = int'(pr_col) + dx / div;
        r = int'(pr_row) - dy / div;
        if (c < 0) c = 0;
        if (c > COLS - 1) c = COLS - 1;
        if (r < 0) r = 0;
        if (r > ROWS - 1) r = ROWS - 1;
        pr_col   = c[6:0];
        pr_row   = r[4:0];
        rpt.col  = pr_col;
        rpt.row  = pr_row;
        rpt.left = pr_status[ST_LEFT];
        if (rpt.left && c == COLS - 1 && r == SWITCH_ROW) begin
            rpt.sw  = 1'b1;
            pr_term = (int'(pr_term) >= TERMS - 1) ? 2'd0 : pr_term + 2'd1;
        end
        rpt.menu = rpt.left && c == COLS - 1 && r == MENU_ROW;
        rpt.pick = rpt.left && c < PICK_COL_LIMIT;
        rpt.term = pr_term;
        return 1'b1;
    endfunction

    task automatic report_mismatch(input string what, input cursor_rpt_t want,
                                   input cursor_rpt_t got);
        n_err++;
        if (n_err <= REPORT_LIMIT)
            $display("%s: want col=%0d row=%0d left=%0b term=%0d sw=%0b menu=%0b pick=%0b, got col=%0d row=%0d left=%0b term=%0d sw=%0b menu=%0b pick=%0b",
                     what, want.col, want.row, want.left, want.term, want.sw,
                     want.menu, want.pick, got.col, got.row, got.left, got.term,
                     got.sw, got.menu, got.pick);
    endtask

    // all traffic is sampled here, so prediction and check order is fixed
    always @(posedge i_clk) begin : monitor
        cursor_rpt_t rpt;
        cursor_rpt_t got;
        bit          made;
        bit          pinned_now;
        bit          moved;
        if (i_rst_n) begin
            moved = 1'b0;
            if (i_cfg_valid && o_cfg_ready) begin
                pr_sens = i_sensitivity;
                n_cfg++;
                moved = 1'b1;
            end
            if (i_in_valid && !o_in_stall) begin
                n_bytes++;
                moved      = 1'b1;
                pinned_now = pin_on && pr_phase == PH_YMOVE;
                made       = advance_cursor(i_data_byte, rpt);
                if (pinned_now) begin
                    if (pin_has) cursor_q.push_back(pin_val);
                    pin_on = 1'b0;
                end else if (made) begin
                    cursor_q.push_back(rpt);
                end
            end
            if (o_out_valid && !i_out_stall) begin
                got = {o_cursor_col, o_cursor_row, o_left_pressed, o_terminal_index,
                       o_switch_hit, o_menu_hit, o_pick_hit};
                n_rpts++;
                moved = 1'b1;
                if (cursor_q.size() == 0) begin
                    report_mismatch("report with none pending", '0, got);
                end else begin
                    rpt = cursor_q.pop_front();
                    if (got !== rpt) report_mismatch("cursor report differs", rpt, got);
                end
            end
            quiet_cycles = moved ? 0 : quiet_cycles + 1;
        end
    end

    initial begin : watchdog
        while (quiet_cycles < QUIET_LIMIT) @(posedge i_clk);
        $display("no traffic for %0d cycles, %0d reports still pending",
                 QUIET_LIMIT, cursor_q.size());
        $display("ps2_mouse_cursor_tracker: mismatch");
        $finish;
    end

    initial begin : out_backpressure
        int burst;
        forever begin
            @(posedge i_clk);
            if (!calm && $urandom_range(0, 9) == 0) begin
                burst = $urandom_range(1, 18);
                i_out_stall <= 1'b1;
                repeat (burst) @(posedge i_clk);
                i_out_stall <= 1'b0;
            end
        end
    end

    // valid stays high across back-to-back requests; lowered only for a gap
    task automatic send_byte(input logic [7:0] b);
        int gap;
        if (!calm && $urandom_range(0, 5) == 0) begin
            gap = $urandom_range(1, 18);
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid  <= 1'b1;
        i_data_byte <= b;
        @(posedge i_clk);
        while (o_in_stall) @(posedge i_clk);
        drv_count++;
    endtask

    // only with nothing in flight; dropped packets leave no trace, so drain too
    task automatic write_sensitivity(input logic [3:0] v);
        i_in_valid <= 1'b0;
        while (cursor_q.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        i_cfg_valid   <= 1'b1;
        i_sensitivity <= v;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        i_cfg_valid <= 1'b0;
    endtask

    function automatic logic [3:0] pick_sensitivity();
        case ($urandom_range(0, 4))
            0:       return 4'd0;
            1:       return 4'd1;
            2:       return 4'd15;
            default: return 4'($urandom);
        endcase
    endfunction

    task automatic send_random_packet();
        logic [7:0] st, xb, yb;
        int         div, target, dyv;
        st = 8'($urandom);
        st[ST_SYNC] = ($urandom_range(0, 9) != 0);
        if ($urandom_range(0, 7) != 0) begin
            st[ST_X_OVF] = 1'b0;
            st[ST_Y_OVF] = 1'b0;
        end
        xb = 8'($urandom);
        yb = 8'($urandom);
        case ($urandom_range(0, 3))
            0: begin
                // full-range movement
            end
            1, 2: begin
                xb = st[ST_X_SIGN] ? 8'(256 - $urandom_range(1, 40)) : 8'($urandom_range(0, 40));
                yb = st[ST_Y_SIGN] ? 8'(256 - $urandom_range(1, 40)) : 8'($urandom_range(0, 40));
            end
            default: begin
                // push right and aim at the switch or menu row
                div    = (pr_sens == 4'd0) ? 1 : int'(pr_sens);
                target = $urandom_range(SWITCH_ROW, MENU_ROW);
                dyv    = (int'(pr_row) - target) * div;
                if (dyv > 255) dyv = 255;
                if (dyv < -255) dyv = -255;
                st[ST_X_SIGN] = 1'b0;
                st[ST_Y_SIGN] = (dyv < 0);
                xb = 8'hFF;
                yb = 8'(dyv);
            end
        endcase
        send_byte(st);
        send_byte(xb);
        send_byte(yb);
    endtask

    initial begin : stimulus
        pkt_row_t r;
        int       total;
        int       roll;
        int       stray;

        //            status xmove  ymove  cfg   sens   pin   rpt   col    row   l    term sw   mn   pk
        plan.push_back('{8'h09, 8'h00, 8'h00, 1'b0, 4'd0, 1'b1, 1'b1,
                        {7'd0,  5'd0,  1'b1, 2'd0, 1'b0, 1'b0, 1'b1}});
        plan.push_back('{8'h28, 8'hFF, 8'h00, 1'b0, 4'd0, 1'b1, 1'b1,
                        {7'd79, 5'd24, 1'b0, 2'd0, 1'b0, 1'b0, 1'b0}});
        plan.push_back('{8'h18, 8'h00, 8'hFF, 1'b0, 4'd0, 1'b1, 1'b1,
                        {7'd0,  5'd0,  1'b0, 2'd0, 1'b0, 1'b0, 1'b0}});
        // sync bit clear, then both overflow bits: dropped
        plan.push_back('{8'h01, 8'hFF, 8'hFF, 1'b0, 4'd0, 1'b1, 1'b0, '0});
        plan.push_back('{8'hC8, 8'h7F, 8'h7F, 1'b0, 4'd0, 1'b1, 1'b0, '0});
        // switch hotspot three times: terminal wraps back to 0
        plan.push_back('{8'h29, 8'hFF, 8'hFE, 1'b0, 4'd0, 1'b1, 1'b1,
                        {7'd79, 5'd1,  1'b1, 2'd1, 1'b1, 1'b0, 1'b0}});
        plan.push_back('{8'h09, 8'h00, 8'h00, 1'b0, 4'd0, 1'b1, 1'b1,
                        {7'd79, 5'd1,  1'b1, 2'd2, 1'b1, 1'b0, 1'b0}});
        plan.push_back('{8'h09, 8'h00, 8'h00, 1'b0, 4'd0, 1'b1, 1'b1,
                        {7'd79, 5'd1,  1'b1, 2'd0, 1'b1, 1'b0, 1'b0}});
        plan.push_back('{8'h29, 8'h00, 8'hFE, 1'b0, 4'd0, 1'b1, 1'b1,
                        {7'd79, 5'd2,  1'b1, 2'd0, 1'b0, 1'b1, 1'b0}});
        // -1 / 2 truncates to no movement
        plan.push_back('{8'h38, 8'hFF, 8'hFF, 1'b0, 4'd0, 1'b1, 1'b1,
                        {7'd79, 5'd2,  1'b0, 2'd0, 1'b0, 1'b0, 1'b0}});
        // zero sensitivity acts as one, then the extremes
        plan.push_back('{8'h19, 8'hFD, 8'h03, 1'b1, 4'd0,  1'b0, 1'b0, '0});
        plan.push_back('{8'h08, 8'h7F, 8'h80, 1'b1, 4'd15, 1'b0, 1'b0, '0});
        plan.push_back('{8'h3B, 8'h9C, 8'h01, 1'b1, 4'd1,  1'b0, 1'b0, '0});

        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (plan[k]) begin
            r = plan[k];
            if (r.new_sens) write_sensitivity(r.sens);
            send_byte(r.st);
            send_byte(r.xb);
            if (r.pinned) begin
                pin_has = r.has_rpt;
                pin_val = r.want;
                pin_on  = 1'b1;
            end
            send_byte(r.yb);
        end

        write_sensitivity(SENS_RESET);
        total = drv_count + RANDOM_BYTES;
        while (drv_count < total) begin
            if (drv_count >= total - CALM_BYTES) calm = 1'b1;
            roll = $urandom_range(0, 99);
            if (roll < 3 && !calm) begin
                write_sensitivity(pick_sensitivity());
            end else if (roll < 9) begin
                // stray bytes knock the packet framing out of step
                stray = $urandom_range(1, 2);
                repeat (stray) send_byte(8'($urandom));
            end else begin
                // mostly get back in step before a fresh packet
                if (roll < 80)
                    while (drv_count % 3 != 0) send_byte(8'($urandom));
                send_random_packet();
            end
        end

        i_in_valid <= 1'b0;
        while (cursor_q.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        $display("covered %0d mouse bytes, %0d cursor reports checked, %0d sensitivity writes",
                 n_bytes, n_rpts, n_cfg);
        $display("%0d mismatches seen", n_err);
        if (n_err == 0) begin
            $display("ps2_mouse_cursor_tracker: match");
        end else begin
            $display("ps2_mouse_cursor_tracker: mismatch");
        end
        $finish;
    end

endmodule

// ===== sim.f =====
src/mcur_pkg.sv
src/mcur_front.sv
src/mcur_queue.sv
src/mcur_back.sv
src/ps2_mouse_cursor_tracker.sv
src/mcur_checker.sv
verif/ps2_mouse_cursor_tracker_tb.sv
